### sv/lru_key_value_cache_macros.svh
// Assertion macros shared by the checker of the key-value cache.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LKV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/lkv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by the cell, the top level and the checker.
package lkv_pkg;

	localparam int unsigned KEY_W     = 32;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned CAP_W     = 5;
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 40;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Operation codes on the func field
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_SET = 1'b1;

	// One cache entry as it travels along the chain
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// Lookup result rippling toward cell zero
	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value;
	} look_t;

	// Broadcast controls from the top level to every cell
	typedef struct packed {
		logic             step;
		logic             hit;
		logic             insert;
		logic [KEY_W-1:0] key;
	} ctl_t;

endpackage

### sv/lkv_cell.sv
`timescale 1ns / 1ps
// One cell of the recency-ordered entry chain: holds an entry, compares its key,
// and loads from its more recent neighbor when the chain shifts. Uses lkv_pkg.
module lkv_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned LIM_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lkv_pkg::ctl_t      ctl,
	input  logic [LIM_W-1:0]   lim,
	input  lkv_pkg::entry_t    prev,
	output lkv_pkg::entry_t    cur,
	input  lkv_pkg::look_t     look_in,
	output lkv_pkg::look_t     look_out
);
	import lkv_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             match;
	logic             take;

	// Compare the stored key and merge into the rippling lookup result
	always_comb begin
		match          = valid_q && (key_q == ctl.key);
		look_out.found = look_in.found | match;
		look_out.value = look_in.value | (match ? value_q : '0);
	end

	// Shift on a hit up to the hit cell, on an insert up to the limit
	always_comb begin
		if (ctl.hit) begin
			take = ctl.step && look_out.found;
		end else begin
			take = ctl.step && ctl.insert && (LIM_W'(INDEX) < lim);
		end
	end

	// Clear valid under reset; load it from the neighbor on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= prev.valid;
		end
	end

	// Advance key and value from the neighbor
	always_ff @(posedge clk) begin
		if (take) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	assign cur.valid = valid_q;
	assign cur.key   = key_q;
	assign cur.value = value_q;

endmodule

### sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Top level of the fully associative LRU key-value cache.
// Uses lkv_pkg and a chain of lkv_cell instances.
//
//   channel  | direction | contents (lowest bit first)
//   s_*      | in        | tdata: func[0], key[32:1], value[64:33], zero pad
//   m_*      | out       | tdata: hit[0], read_value[32:1], zero pad
//   cfg_*    | in        | capacity_in_use write, no read-back
//
// Each word is registered first, and no new word is accepted while one is held; then
// every cell compares its key, the lookup ripples down the chain and the chain shifts.
// The entry chain is ordered by recency, cell zero most recent; no reset sweep.
// A pending result that is not taken stalls the update stage; the input side
// still accepts one word while the result waits.
module lru_key_value_cache #(
	parameter int unsigned MAX_ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lkv_pkg::S_TDATA_W-1:0]  s_tdata,  // func, key, value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lkv_pkg::M_TDATA_W-1:0]  m_tdata,  // hit, read_value
	input  logic                           cfg_wr_en,
	input  logic [lkv_pkg::CAP_W-1:0]      cfg_wr_data
);
	import lkv_pkg::*;

	localparam int unsigned OCC_W = $clog2(MAX_ENTRIES + 2);
	localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic             busy_s1;
	logic             func_s1;
	logic [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] val_s1;

	logic [CAP_W-1:0] cap_q;
	logic [OCC_W-1:0] occ_q;
	logic             hit_q;
	logic [VAL_W-1:0] rdval_q;
	logic             mvalid_q;

	logic             s_acc;
	logic             step;
	logic             full;
	logic [CMP_W-1:0] eff_cap;
	logic [OCC_W-1:0] lim;
	ctl_t             ctl;
	entry_t           ent [MAX_ENTRIES+1];
	look_t            lk  [MAX_ENTRIES+1];

	assign s_tready = !busy_s1;
	assign s_acc    = s_tvalid && s_tready;
	assign step     = busy_s1 && (!mvalid_q || m_tready);

	// Clamp capacity to 1..MAX_ENTRIES and decide whether an insert evicts
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
		full = CMP_W'(occ_q) >= eff_cap;
		lim  = full ? occ_q : occ_q + OCC_W'(1);
	end

	// Broadcast controls to the chain
	always_comb begin
		ctl.step   = step;
		ctl.hit    = lk[0].found;
		ctl.insert = (func_s1 == FUNC_SET) && !lk[0].found;
		ctl.key    = key_s1;
	end

	// New most-recent entry enters ahead of cell zero
	assign ent[0].valid = 1'b1;
	assign ent[0].key   = key_s1;
	assign ent[0].value = (func_s1 == FUNC_SET) ? val_s1 : lk[0].value;

	assign lk[MAX_ENTRIES].found = 1'b0;
	assign lk[MAX_ENTRIES].value = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lkv_cell #(
			.INDEX (i),
			.LIM_W (OCC_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.lim      (lim),
			.prev     (ent[i]),
			.cur      (ent[i+1]),
			.look_in  (lk[i+1]),
			.look_out (lk[i])
		);
	end

	// Capture the input word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (s_acc) begin
			busy_s1 <= 1'b1;
		end else if (step) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			func_s1 <= s_tdata[0];
			key_s1  <= s_tdata[KEY_W:1];
			val_s1  <= s_tdata[KEY_W+VAL_W:KEY_W+1];
		end
	end

	// Hold the capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Count occupied entries; an insert into a full cache evicts one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (step && ctl.insert && !full) begin
			occ_q <= occ_q + OCC_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (step) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			hit_q <= lk[0].found;
			if (func_s1 == FUNC_SET) begin
				rdval_q <= '0;
			end else if (lk[0].found) begin
				rdval_q <= lk[0].value;
			end else begin
				rdval_q <= '1;
			end
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(M_TDATA_W-VAL_W-1){1'b0}}, rdval_q, hit_q};

endmodule

### sv/lkv_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the LRU key-value cache, bound to the top level.
// Uses lkv_pkg and the assertion macros header.
`include "lru_key_value_cache_macros.svh"

module lkv_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [lkv_pkg::S_TDATA_W-1:0]  s_tdata,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [lkv_pkg::M_TDATA_W-1:0]  m_tdata
);
	import lkv_pkg::*;

	logic s_acc;
	logic miss_val_ok;

	assign s_acc       = s_tvalid && s_tready && (s_tdata[0] == FUNC_GET || s_tdata[0] == FUNC_SET);
	assign miss_val_ok = (m_tdata[VAL_W:1] == '0) || (m_tdata[VAL_W:1] == '1);

	// Stalled result word holds
	`LKV_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed under stall")

	// One word in flight: no accept right after an accept
	`LKV_ASSERT_NEXT(a_one_inflight, clk, arst_n, s_acc, !s_tready, "input accepted while busy")

	// After an accept, a result word must be showing on the output
	`LKV_ASSERT_NOW(a_result_due, clk, arst_n, s_acc, ##2 m_tvalid, "result missing after accept")

	// A miss reports either the get-miss code or the set acknowledge
	`LKV_ASSERT_NOW(a_miss_value, clk, arst_n, m_tvalid && !m_tdata[0], miss_val_ok, "bad value on miss")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_key_value_cache: streams get/set words, predicts every reply
// with an LRU model of its own and compares the replies in order, field by field.
// Depends on lkv_pkg and the lru_key_value_cache RTL.
module tb;
	import lkv_pkg::*;

	localparam int SLOTS = 16;
	localparam int POOL_SIZE = 24;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;
	localparam logic [VAL_W-1:0] ACK_VALUE = '0;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] value;
	} reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // func, key, value
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // hit, read_value
	logic                 cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]     cfg_wr_data = '0;

	// predicted cache contents
	logic             slot_valid [SLOTS];
	logic [KEY_W-1:0] slot_key [SLOTS];
	logic [VAL_W-1:0] slot_value [SLOTS];
	int               slot_age [SLOTS];
	int               fill_count = 0;
	logic [CAP_W-1:0] capacity_reg = CAP_RESET;

	reply_t           pending_replies [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int mismatch_count = 0;
	int cycle_count = 0;
	int words_sent = 0;
	int get_hits = 0;
	int get_misses = 0;
	int set_count = 0;
	int evict_count = 0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	int hold_req = 0;
	int hold_left = 0;

	lru_key_value_cache #(.MAX_ENTRIES(SLOTS)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] corner_value(input int idx);
		case (idx)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			default: return 32'h8000_0000;
		endcase
	endfunction

	// Make slot s most recent; valid entries younger than limit age by one
	function automatic void make_recent(input int s, input int limit);
		for (int i = 0; i < SLOTS; i++)
			if (i != s && slot_valid[i] && slot_age[i] < limit)
				slot_age[i]++;
		slot_age[s] = 0;
	endfunction

	// Apply one word to the predicted cache and return the reply it must produce
	function automatic reply_t predict_reply(input logic op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		int found;
		int victim;
		int oldest;
		int eff;
		found = -1;
		victim = -1;
		oldest = 0;
		eff = (capacity_reg == 0) ? 1 : ((capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg));
		for (int i = 0; i < SLOTS; i++)
			if (found < 0 && slot_valid[i] && slot_key[i] == k)
				found = i;

		if (op == FUNC_GET) begin
			if (found >= 0) begin
				make_recent(found, slot_age[found]);
				get_hits++;
				return '{hit: 1'b1, value: slot_value[found]};
			end
			get_misses++;
			return '{hit: 1'b0, value: MISS_VALUE};
		end

		set_count++;
		// update in place
		if (found >= 0) begin
			slot_value[found] = v;
			make_recent(found, slot_age[found]);
			return '{hit: 1'b1, value: ACK_VALUE};
		end
		// full: drop the least recent valid entry
		if (fill_count >= eff) begin
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && (victim < 0 || slot_age[i] >= oldest)) begin
					victim = i;
					oldest = slot_age[i];
				end
			if (victim >= 0) begin
				slot_valid[victim] = 1'b0;
				evict_count++;
			end else
				fill_count = 0;
		end
		// not full: take the first free slot
		if (victim < 0) begin
			for (int i = 0; i < SLOTS; i++)
				if (victim < 0 && !slot_valid[i])
					victim = i;
			if (victim < 0)
				victim = 0;
			else
				fill_count++;
		end
		slot_key[victim] = k;
		slot_value[victim] = v;
		make_recent(victim, SLOTS + 1);
		slot_valid[victim] = 1'b1;
		return '{hit: 1'b0, value: ACK_VALUE};
	endfunction

	// Offer one word, wait for the handshake, record its reply, then maybe idle
	task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - KEY_W - VAL_W - 1){1'b0}}, v, k, op};
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(predict_reply(op, k, v));
		words_sent++;
		// idle gap with noise on the data lines
		if (src_idle_on && $urandom_range(99) < 32) begin
			s_tvalid <= 1'b0;
			do begin
				s_tdata <= S_TDATA_W'({$urandom, $urandom, $urandom});
				@(posedge clk);
			end while ($urandom_range(99) < 32);
		end
	endtask

	// Write the capacity once every reply is back and the block has settled
	task automatic set_capacity(input logic [CAP_W-1:0] cap);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= cap;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		capacity_reg = cap;
	endtask

	// Receiver: random stalls, plus a long hold-off counted here when requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (snk_idle_on)
			m_tready <= ($urandom_range(99) >= 32);
		else
			m_tready <= 1'b1;
	end

	// Compare each accepted reply with the oldest prediction
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected reply, expected none, got hit=%0b value=%h",
					$time, m_tdata[0], m_tdata[VAL_W:1]);
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata[0] !== want.hit) begin
					mismatch_count++;
					$display("%0t: hit mismatch, expected %0b, got %0b",
						$time, want.hit, m_tdata[0]);
				end
				if (m_tdata[VAL_W:1] !== want.value) begin
					mismatch_count++;
					$display("%0t: read_value mismatch, expected %h, got %h",
						$time, want.value, m_tdata[VAL_W:1]);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d replies outstanding", $time, pending_replies.size());
			$display("tb: errors");
			$finish;
		end
	end

	// Corner keys and values, updates, a get of a stored all-ones value
	task automatic test_basic_ops();
		send_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send_word(FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(FUNC_SET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_word(FUNC_SET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		send_word(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_word(FUNC_SET, 32'h0000_0000, 32'h1234_5678);
		send_word(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send_word(FUNC_GET, 32'h0000_0001, 32'hFFFF_FFFF);
	endtask

	// Small capacity below occupancy: a get must refresh recency before an eviction
	task automatic test_lru_order();
		set_capacity(5'd2);
		send_word(FUNC_SET, 32'h0000_0A0A, 32'h0000_0001);
		send_word(FUNC_SET, 32'h0000_0B0B, 32'h0000_0002);
		send_word(FUNC_GET, 32'h0000_0A0A, 32'h0000_0000);
		send_word(FUNC_SET, 32'h0000_0C0C, 32'h0000_0003);
		send_word(FUNC_GET, 32'h0000_0B0B, 32'h0000_0000);
		send_word(FUNC_GET, 32'h0000_0A0A, 32'h0000_0000);
		send_word(FUNC_GET, 32'h0000_0C0C, 32'h0000_0000);
	endtask

	// Capacity zero acts as one; capacity above the entry count saturates
	task automatic test_capacity_clamp();
		set_capacity(5'd0);
		send_word(FUNC_SET, 32'h0000_0D0D, 32'h0000_0001);
		send_word(FUNC_SET, 32'h0000_0E0E, 32'h0000_0002);
		send_word(FUNC_GET, 32'h0000_0D0D, 32'h0000_0000);
		send_word(FUNC_GET, 32'h0000_0E0E, 32'h0000_0000);
		set_capacity(5'd31);
		send_word(FUNC_SET, 32'h5555_5555, 32'hAAAA_AAAA);
		send_word(FUNC_SET, 32'hAAAA_AAAA, 32'h5555_5555);
		send_word(FUNC_GET, 32'h0000_0E0E, 32'h0000_0000);
		send_word(FUNC_GET, 32'h5555_5555, 32'h0000_0000);
	endtask

	// Random gets and sets over a key pool sized to the capacity
	task automatic test_random_phase(input logic [CAP_W-1:0] cap, input int n_words,
			input bit quiet);
		int eff;
		int span;
		int base;
		logic op;
		logic [KEY_W-1:0] k;
		logic [VAL_W-1:0] v;
		set_capacity(cap);
		src_idle_on = !quiet;
		snk_idle_on = !quiet;
		eff = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : int'(cap));
		span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
		base = $urandom_range(POOL_SIZE - span);
		repeat (n_words) begin
			op = ($urandom_range(99) < 45) ? FUNC_GET : FUNC_SET;
			k = ($urandom_range(99) < 85) ? key_pool[base + $urandom_range(span - 1)] : $urandom;
			v = ($urandom_range(9) == 0) ? corner_value($urandom_range(3)) : $urandom;
			send_word(op, k, v);
		end
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
	endtask

	// Hold the output off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		set_capacity(CAP_RESET);
		hold_req = HOLD_CYCLES;
		test_random_phase(CAP_RESET, 40, 1'b1);
	endtask

	// Sweep capacities, including the clamp extremes and one stretch with no idling
	task automatic test_random_mix();
		logic [CAP_W-1:0] caps [10] = '{5'd3, 5'd1, 5'd0, 5'd31, 5'd8,
			5'd5, 5'd2, 5'd12, 5'd16, 5'd9};
		for (int i = 0; i < 10; i++)
			test_random_phase(caps[i], 68, i == 4);
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_valid[i] = 1'b0;
			slot_key[i] = '0;
			slot_value[i] = '0;
			slot_age[i] = 0;
		end
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i < 4) ? corner_value(i) : $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_lru_order();
		test_capacity_clamp();
		test_backpressure();
		test_random_mix();

		// drain
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d words: %0d sets, %0d get hits, %0d get misses, %0d evictions",
			words_sent, set_count, get_hits, get_misses, evict_count);
		$display("summary: capacities 0 to 31 with clamping, one %0d-cycle output hold, %0d mismatches",
			HOLD_CYCLES, mismatch_count);
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/lkv_pkg.sv
sv/lkv_cell.sv
sv/lru_key_value_cache.sv
sv/lkv_checker.sv
sim/tb.sv
